### rtl/lsfg_pkg.sv
// ---------------------------------------------------------------------------
// lsfg_pkg: shared types and constants of the led strip frame generator
// Word formats, command and register codes, pixel layout and the
// sequencer states.
// ---------------------------------------------------------------------------
package lsfg_pkg;

    // default strip capacity
    localparam int MAX_LEDS_DEF = 32;

    // field widths
    localparam int CMD_W   = 2;
    localparam int CNT_W   = 6;
    localparam int COLOR_W = 8;
    localparam int PCT_W   = 7;
    localparam int LVL_W   = 5;
    localparam int BYTES_W = 3;
    localparam int WORD_W  = 32;
    localparam int PROD_W  = PCT_W + LVL_W;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] REG_LED_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_LEVEL = 1'd1;
    localparam logic [CNT_W-1:0]     LED_COUNT_RESET  = 6'd32;
    localparam logic [LVL_W-1:0]     GLOBAL_RESET     = 5'd31;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SHOW  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // result codes
    localparam logic KIND_STATUS      = 1'b0;
    localparam logic KIND_FRAME       = 1'b1;
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_INDEX = 1'b1;

    // brightness scaling: floor(p / 100) as (p * RECIP_100) >> LVL_LSB, exact for p <= 3100
    localparam int                 RECIP_W   = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int                 LVL_LSB   = 19;
    localparam int                 SCALE_W   = 24;

    localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0]   PCT_RESET  = 7'd50;
    localparam logic [7:0]         START_MARK = 8'hE0;
    localparam logic [BYTES_W-1:0] FULL_BYTES = 3'd4;
    localparam int                 END_SHIFT  = 4;
    localparam logic [CNT_W:0]     END_ROUND  = 7'd15;

    // one stored pixel
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [PCT_W-1:0]   percent;
    } t_pixel;

    localparam t_pixel PIXEL_RESET = '{8'd0, 8'd0, 8'd0, 7'd50};

    // input word
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CNT_W-1:0]   pixel_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [PCT_W-1:0]   percent;
    } t_in_word;

    // output word
    typedef struct packed {
        logic               kind;
        logic [WORD_W-1:0]  frame_word;
        logic [BYTES_W-1:0] byte_count;
        logic               status;
        logic               last;
    } t_out_word;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_STATUS,
        S_START,
        S_PIX_MUL,
        S_PIX_DIV,
        S_END
    } t_state;

endpackage

### rtl/lsfg_ram.sv
// ---------------------------------------------------------------------------
// lsfg_ram: generic single-clock ram
// One write port, one read port, read data registered.
// ---------------------------------------------------------------------------
module lsfg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/led_strip_frame_generator.sv
// ---------------------------------------------------------------------------
// led_strip_frame_generator: pixel store and serial led frame builder
// Write command stores one pixel if its index is in range; show emits start word, one
// word per led and the end word; clear shows the leds in use as black and blanks them.
// ---------------------------------------------------------------------------
// Pixel write: the status word is loaded at the accepting edge, or held in S_STATUS
//   with the input blocked until the output register frees.
// Show and clear: S_START loads the start word, then per led S_PIX_MUL multiplies and
//   S_PIX_DIV does the reciprocal step and word load, next pixel read meanwhile; then
//   S_END loads the end word and the next command is taken back in S_IDLE. A stalled
//   output holds S_START, S_PIX_DIV and S_END.
// Reset: control state cleared, led_count 32, global_level 31; per-entry valid bits
//   clear at once so every pixel reads black at fifty percent, no clearing pass.
module led_strip_frame_generator #(
    parameter int MAX_LEDS = lsfg_pkg::MAX_LEDS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lsfg_pkg::t_in_word                  i_in_word,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lsfg_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_we,
    input  logic [lsfg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsfg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int ADDR_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int PIX_W  = $bits(lsfg_pkg::t_pixel);
    localparam logic [lsfg_pkg::CNT_W-1:0] MAX_CNT = lsfg_pkg::CNT_W'(MAX_LEDS);

    // registers
    lsfg_pkg::t_state                 r_state, n_state;
    logic                             r_out_valid, n_out_valid;
    lsfg_pkg::t_out_word              r_out, n_out;
    logic                             r_bad, n_bad;
    logic                             r_clear, n_clear;
    logic [lsfg_pkg::CNT_W-1:0]       r_pix, n_pix;
    logic [lsfg_pkg::CNT_W-1:0]       r_led_count;
    logic [lsfg_pkg::LVL_W-1:0]       r_global_level;
    logic [MAX_LEDS-1:0]              r_valid;
    logic                             r_rd_vld;
    logic [lsfg_pkg::PROD_W-1:0]      r_prod;
    logic [3*lsfg_pkg::COLOR_W-1:0]   r_rgb;

    // combinational
    logic                             in_accept;
    logic                             out_free;
    logic [lsfg_pkg::CNT_W-1:0]       eff_cnt;
    logic                             idx_ok;
    logic [lsfg_pkg::PCT_W-1:0]       pct_sat;
    logic                             ram_we;
    logic [ADDR_W-1:0]                ram_waddr;
    lsfg_pkg::t_pixel                 ram_wdata;
    logic [ADDR_W-1:0]                ram_raddr;
    logic [PIX_W-1:0]                 ram_q;
    lsfg_pkg::t_pixel                 pix_cur;
    logic [lsfg_pkg::SCALE_W-1:0]     scaled;
    logic [lsfg_pkg::LVL_W-1:0]       lvl;
    logic [lsfg_pkg::WORD_W-1:0]      pix_word;
    logic [lsfg_pkg::CNT_W:0]         end_sum;
    logic [lsfg_pkg::BYTES_W-1:0]     end_bytes;
    lsfg_pkg::t_out_word              status_word;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // led count in use, clamped to 1..MAX_LEDS
    always_comb begin
        if (r_led_count == '0) begin
            eff_cnt = lsfg_pkg::CNT_W'(1);
        end else if (r_led_count > MAX_CNT) begin
            eff_cnt = MAX_CNT;
        end else begin
            eff_cnt = r_led_count;
        end
    end

    assign idx_ok  = i_in_word.pixel_index < eff_cnt;
    assign pct_sat = (i_in_word.percent > lsfg_pkg::PCT_MAX) ? lsfg_pkg::PCT_MAX
                                                             : i_in_word.percent;

    // end word carries ceil(n/16) zero bytes
    assign end_sum   = {1'b0, eff_cnt} + lsfg_pkg::END_ROUND;
    assign end_bytes = end_sum[lsfg_pkg::END_SHIFT +: lsfg_pkg::BYTES_W];

    // pixel as read back, unwritten entries at reset value, blank while clearing
    always_comb begin
        if (r_clear) begin
            pix_cur = '0;
        end else if (r_rd_vld) begin
            pix_cur = lsfg_pkg::t_pixel'(ram_q);
        end else begin
            pix_cur = lsfg_pkg::PIXEL_RESET;
        end
    end

    // second scaling step: divide by 100 through the reciprocal
    assign scaled   = lsfg_pkg::SCALE_W'({{(lsfg_pkg::SCALE_W - lsfg_pkg::PROD_W){1'b0}}, r_prod}
                      * {{(lsfg_pkg::SCALE_W - lsfg_pkg::RECIP_W){1'b0}}, lsfg_pkg::RECIP_100});
    assign lvl      = scaled[lsfg_pkg::LVL_LSB +: lsfg_pkg::LVL_W];
    assign pix_word = {lsfg_pkg::START_MARK | {3'b000, lvl}, r_rgb};

    // status word for a pixel write
    always_comb begin
        status_word            = '0;
        status_word.kind       = lsfg_pkg::KIND_STATUS;
        status_word.status     = r_bad;
        status_word.last       = 1'b1;
    end

    // sequencer: next state, output register loads, ram ports
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_bad       = r_bad;
        n_clear     = r_clear;
        n_pix       = r_pix;
        o_in_ready  = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = i_in_word.pixel_index[ADDR_W-1:0];
        ram_wdata   = '{i_in_word.red, i_in_word.green, i_in_word.blue, pct_sat};
        ram_raddr   = r_pix[ADDR_W-1:0];
        unique case (r_state)
            lsfg_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_accept) begin
                    n_clear = (i_in_word.cmd == lsfg_pkg::CMD_CLEAR);
                    case (i_in_word.cmd) inside
                        lsfg_pkg::CMD_WRITE: begin
                            ram_we = idx_ok;
                            n_bad  = idx_ok ? lsfg_pkg::STATUS_OK
                                            : lsfg_pkg::STATUS_BAD_INDEX;
                            if (out_free) begin
                                n_out_valid       = 1'b1;
                                n_out             = '0;
                                n_out.kind        = lsfg_pkg::KIND_STATUS;
                                n_out.status      = !idx_ok;
                                n_out.last        = 1'b1;
                            end else begin
                                n_state = lsfg_pkg::S_STATUS;
                            end
                        end
                        lsfg_pkg::CMD_SHOW, lsfg_pkg::CMD_CLEAR: begin
                            n_state = lsfg_pkg::S_START;
                        end
                        default: begin
                            n_state = lsfg_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            lsfg_pkg::S_STATUS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = status_word;
                    n_state     = lsfg_pkg::S_IDLE;
                end
            end
            lsfg_pkg::S_START: begin
                ram_raddr = '0;
                n_pix     = '0;
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.kind       = lsfg_pkg::KIND_FRAME;
                    n_out.byte_count = lsfg_pkg::FULL_BYTES;
                    n_state          = lsfg_pkg::S_PIX_MUL;
                end
            end
            lsfg_pkg::S_PIX_MUL: begin
                n_state = lsfg_pkg::S_PIX_DIV;
            end
            lsfg_pkg::S_PIX_DIV: begin
                ram_waddr = r_pix[ADDR_W-1:0];
                ram_wdata = '0;
                if (out_free) begin
                    ram_we           = r_clear;
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.kind       = lsfg_pkg::KIND_FRAME;
                    n_out.frame_word = pix_word;
                    n_out.byte_count = lsfg_pkg::FULL_BYTES;
                    if (r_pix == eff_cnt - lsfg_pkg::CNT_W'(1)) begin
                        n_state = lsfg_pkg::S_END;
                    end else begin
                        n_pix     = r_pix + lsfg_pkg::CNT_W'(1);
                        ram_raddr = n_pix[ADDR_W-1:0];
                        n_state   = lsfg_pkg::S_PIX_MUL;
                    end
                end
            end
            lsfg_pkg::S_END: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_out            = '0;
                    n_out.kind       = lsfg_pkg::KIND_FRAME;
                    n_out.byte_count = end_bytes;
                    n_out.last       = 1'b1;
                    n_state          = lsfg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lsfg_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsfg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count    <= lsfg_pkg::LED_COUNT_RESET;
            r_global_level <= lsfg_pkg::GLOBAL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lsfg_pkg::REG_LED_COUNT:    r_led_count    <= i_cfg_data;
                lsfg_pkg::REG_GLOBAL_LEVEL: r_global_level <= i_cfg_data[lsfg_pkg::LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // payload registers and first scaling step
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_bad    <= n_bad;
        r_clear  <= n_clear;
        r_pix    <= n_pix;
        r_rd_vld <= r_valid[ram_raddr];
        if (r_state == lsfg_pkg::S_PIX_MUL) begin
            r_prod <= {{lsfg_pkg::LVL_W{1'b0}}, pix_cur.percent}
                      * {{lsfg_pkg::PCT_W{1'b0}}, r_global_level};
            r_rgb  <= {pix_cur.red, pix_cur.green, pix_cur.blue};
        end
    end

    // pixel store
    lsfg_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_LEDS)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // pixel counter stays inside the strip while walking it
    a_pix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsfg_pkg::S_PIX_MUL || r_state == lsfg_pkg::S_PIX_DIV)
        |-> (r_pix < eff_cnt))
        else $error("pixel counter beyond led count");

    // store is written only by an accepted pixel write or a clearing pass
    a_ram_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == lsfg_pkg::S_IDLE && in_accept)
                    || (r_state == lsfg_pkg::S_PIX_DIV && r_clear)))
        else $error("unexpected pixel store write");

    // end word closes the frame and returns to idle
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lsfg_pkg::S_END && out_free)
        |=> (r_state == lsfg_pkg::S_IDLE && o_out_valid && o_out_word.last
             && o_out_word.kind == lsfg_pkg::KIND_FRAME))
        else $error("end word not delivered");

    // status words never carry frame bytes
    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.kind == lsfg_pkg::KIND_STATUS)
        |-> (o_out_word.byte_count == '0 && o_out_word.frame_word == '0
             && o_out_word.last))
        else $error("status word with frame content");

endmodule
